[sv/sha_pkg.sv]
// Package: SHA-256 constants, a rotate-right helper and shared types.
package sha_pkg;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] PAD_MARK = 32'h80000000;

  typedef logic [31:0] word_t;

  // handshake between sequencer and round unit
  typedef struct packed {
    logic       start;   // load working vars from chain value
    logic       step;    // run one round
    logic       finish;  // fold working vars into chain value
    logic       clear;   // back to initial hash
    logic [5:0] round;
  } rnd_ctl_t;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[sv/sha256_message_digest_top.sv]
// Top level: SHA-256 streaming digest with word buffer, sequencer and output.
//  channel | signals                                   | dir
//  in      | valid, stall, data_word, byte_count, last_word | in (stall out)
//  out     | out_valid, out_stall, digest_word, word_index, last_of_digest | out
// A non-last word is simply taken, except the 16th of a block, which adds the
// load, 64 rounds and fold in the single round unit.
// A last word adds the pad words, one compression per block, then the 8 words.
// Reset (rst, synchronous) clears the chain value to the initial hash.
// stall is high whenever the sequencer is not idle; out_stall holds the word.
module sha256_message_digest_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_of_digest
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_FOLD = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state;
  logic [3:0]  words_in_block;
  logic [5:0]  round;
  logic [63:0] bit_length;
  logic        closing;   // message ended, padding in progress
  logic        len_done;  // length words written
  logic        len_hi;    // upper length word written in slot 14
  logic        mark_done; // 0x80 marker written
  logic [2:0]  out_idx;
  sha_pkg::word_t w [16];
  sha_pkg::word_t hv [8];
  sha_pkg::word_t wt, w15, w2, s0, s1;
  sha_pkg::rnd_ctl_t ctl;
  logic        accept;
  logic [2:0]  n;
  sha_pkg::word_t keep, first_word, pad_word;
  logic        push;
  sha_pkg::word_t push_data;

  assign stall  = (state != S_IDLE);
  assign accept = valid && !stall;

  always_comb begin
    n = (!last_word || byte_count > 3'd4) ? 3'd4 : byte_count;
    keep = (n == 3'd0) ? 32'h0 : ~(32'hffffffff >> {n[1:0], 3'b000});
    first_word = (n == 3'd4) ? data_word
               : ((data_word & keep) | (32'h80 << (5'd24 - {n[1:0], 3'b000})));
  end

  // pad word to write during S_PAD
  always_comb begin
    if (!mark_done) pad_word = sha_pkg::PAD_MARK;
    else if (words_in_block == 4'd14) pad_word = bit_length[63:32];
    else if (words_in_block == 4'd15 && len_hi) pad_word = bit_length[31:0];
    else pad_word = 32'h0;
  end

  assign push = accept || (state == S_PAD);
  assign push_data = accept ? first_word : pad_word;

  // schedule update
  always_comb begin
    w15 = w[4'(round - 6'd15)];
    w2  = w[4'(round - 6'd2)];
    s0 = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
    s1 = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
    wt = (round < 6'd16) ? w[round[3:0]] : (w[round[3:0]] + s0 + w[4'(round - 6'd7)] + s1);
  end

  always_comb begin
    ctl.start  = (state == S_LOAD);
    ctl.step   = (state == S_RUN);
    ctl.finish = (state == S_FOLD);
    ctl.clear  = rst || (state == S_OUT && !out_stall && out_idx == 3'd7);
    ctl.round  = round;
  end

  sha_round u_round (.clk(clk), .ctl(ctl), .wt(wt), .hv(hv));

  always_ff @(posedge clk) begin
    if (push) w[words_in_block] <= push_data;
    if (state == S_RUN) w[round[3:0]] <= wt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      words_in_block <= '0;
      round <= '0;
      bit_length <= '0;
      closing <= 1'b0;
      len_done <= 1'b0;
      len_hi <= 1'b0;
      mark_done <= 1'b0;
      out_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            bit_length <= bit_length + 64'({n, 3'b000});
            words_in_block <= words_in_block + 4'd1;
            if (last_word) begin
              closing <= 1'b1;
              mark_done <= (n != 3'd4);
              state <= (words_in_block == 4'd15) ? S_LOAD : S_PAD;
            end else if (words_in_block == 4'd15) begin
              state <= S_LOAD;
            end
          end
        end
        S_PAD: begin
          mark_done <= 1'b1;
          words_in_block <= words_in_block + 4'd1;
          if (mark_done && words_in_block == 4'd14) len_hi <= 1'b1;
          if (len_hi && words_in_block == 4'd15) len_done <= 1'b1;
          // length only goes in once the marker is placed and slot 14 is reached
          if (words_in_block == 4'd15) state <= S_LOAD;
        end
        S_LOAD: begin
          round <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          if (!closing) state <= S_IDLE;
          else if (len_done) state <= S_OUT;
          else state <= S_PAD;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state <= S_IDLE;
              bit_length <= '0;
              closing <= 1'b0;
              len_done <= 1'b0;
              len_hi <= 1'b0;
              mark_done <= 1'b0;
              words_in_block <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = (state == S_OUT);
  assign digest_word    = hv[out_idx];
  assign word_index     = out_idx;
  assign last_of_digest = (out_idx == 3'd7);

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> stall) else $error("input taken during rounds");
  a_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && round == 6'd63) |=> (state == S_FOLD)) else $error("round count");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_idx))) else $error("digest lost");
  a_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (len_done && closing)) else $error("digest before length");

endmodule

[sv/sha_round.sv]
// Round unit: one SHA-256 round per cycle while step is high, plus chain value update.
module sha_round (
  input  logic             clk,
  input  sha_pkg::rnd_ctl_t ctl,
  input  sha_pkg::word_t   wt,
  output sha_pkg::word_t   hv [8]
);

  sha_pkg::word_t v [8];
  sha_pkg::word_t t1, t2;

  always_comb begin
    t1 = v[7] + (sha_pkg::rotr(v[4], 6) ^ sha_pkg::rotr(v[4], 11) ^ sha_pkg::rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[ctl.round] + wt;
    t2 = (sha_pkg::rotr(v[0], 2) ^ sha_pkg::rotr(v[0], 13) ^ sha_pkg::rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      hv <= sha_pkg::IV;
    end else if (ctl.finish) begin
      for (int i = 0; i < 8; i++) hv[i] <= hv[i] + v[i];
    end
    if (ctl.start) begin
      v <= hv;
    end else if (ctl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule

[tb/tb_sha256_message_digest_top.sv]
// Testbench for the streaming SHA-256 digest: table-driven directed words, then random messages.
module tb_sha256_message_digest_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        stall;
  logic [31:0] data_word = '0;
  logic [2:0]  byte_count = '0;
  logic        last_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_of_digest;

  sha256_message_digest_top u_top (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        lst;
  } digest_t;

  typedef struct {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        lst;
    logic        has_exp;
    logic [31:0] exp0;
  } stim_t;

  // predictor state
  logic [31:0] hash_st [8];
  logic [31:0] blk [16];
  logic [63:0] msg_bits;
  int          blk_fill;

  digest_t digest_q [$];
  int      errors = 0;
  bit      send_done = 0;
  bit      hold_rx = 0;
  int      pause_req = 0;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_reset();
    for (int i = 0; i < 8; i++) hash_st[i] = sha_pkg::IV[i];
    msg_bits = '0;
    blk_fill = 0;
  endtask

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {hash_st[0], hash_st[1], hash_st[2], hash_st[3],
                                hash_st[4], hash_st[5], hash_st[6], hash_st[7]};
    for (int r = 0; r < 64; r++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + sha_pkg::ROUND_K[r] + w[r];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
  endtask

  task automatic add_word(logic [31:0] w);
    blk[blk_fill] = w;
    blk_fill++;
    if (blk_fill == 16) begin
      blk_fill = 0;
      compress();
    end
  endtask

  task automatic predict_word(logic [31:0] d, logic [2:0] c, logic l);
    int n;
    logic [31:0] keep;
    n = (c > 4 || !l) ? 4 : c;
    msg_bits += 64'(n * 8);
    if (!l) begin
      add_word(d);
      return;
    end
    if (n == 4) begin
      add_word(d);
      add_word(sha_pkg::PAD_MARK);
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
      add_word((d & keep) | (32'h80 << (24 - 8 * n)));
    end
    while (blk_fill != 14) add_word(32'h0);
    add_word(msg_bits[63:32]);
    add_word(msg_bits[31:0]);
    for (int i = 0; i < 8; i++) digest_q.push_back('{hash_st[i], 3'(i), i == 7});
    hash_reset();
  endtask

  // offer one word with an optional random gap, wait for acceptance; valid stays up afterwards
  task automatic send(logic [31:0] d, logic [2:0] c, logic l, bit gap);
    int g;
    g = gap ? $urandom_range(0, 15) : 0;
    if (g > 0) begin
      valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    valid <= 1'b1;
    data_word <= d;
    byte_count <= c;
    last_word <= l;
    do @(posedge clk); while (stall);
    predict_word(d, c, l);
  endtask

  // directed table; exp0 is digest word 0 where known at a glance
  stim_t dir_tab [11] = '{
    '{32'h0, 3'd0, 1'b1, 1'b1, 32'he3b0c442},        // empty message
    '{32'h61626300, 3'd3, 1'b1, 1'b1, 32'hba7816bf}, // "abc"
    '{32'h616263ff, 3'd3, 1'b1, 1'b1, 32'hba7816bf}, // junk in invalid byte
    '{32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0},
    '{32'h00000000, 3'd1, 1'b1, 1'b0, 32'h0},
    '{32'hffffffff, 3'd2, 1'b1, 1'b0, 32'h0},
    '{32'hdeadbeef, 3'd7, 1'b1, 1'b0, 32'h0},        // count above four
    '{32'h12345678, 3'd1, 1'b0, 1'b0, 32'h0},        // short but not last
    '{32'h9abcdef0, 3'd5, 1'b0, 1'b0, 32'h0},
    '{32'h0, 3'd0, 1'b0, 1'b0, 32'h0},
    '{32'hffffffff, 3'd6, 1'b1, 1'b0, 32'h0}
  };

  initial begin
    int mlen;
    hash_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].has_exp && dir_tab[i].lst) begin
        send(dir_tab[i].data, dir_tab[i].cnt, dir_tab[i].lst, 1);
        if (digest_q[digest_q.size() - 8].word !== dir_tab[i].exp0) begin
          errors++;
          if (errors <= 10)
            $display("table row %0d: digest word 0 exp %h got %h", i, dir_tab[i].exp0,
                     digest_q[digest_q.size() - 8].word);
        end
      end else begin
        send(dir_tab[i].data, dir_tab[i].cnt, dir_tab[i].lst, 1);
      end
    end
    // messages of 13..18 words across the 14-word boundary
    for (int m = 12; m < 18; m++) begin
      for (int k = 0; k < m; k++) send($urandom, 3'd4, 1'b0, 0);
      send($urandom, 3'($urandom_range(0, 7)), 1'b1, 0);
    end
    // long receiver hold while sender keeps offering words
    hold_rx = 1;
    for (int k = 0; k < 40; k++)
      send($urandom, 3'($urandom_range(0, 7)), (k == 19) || (k == 39), 0);
    // pause until everything drained
    valid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
    for (int tot = 0; tot < 360; ) begin
      mlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      for (int k = 0; k < mlen; k++) begin
        send($urandom, 3'($urandom_range(0, 7)), 1'b0, $urandom_range(0, 3) == 0);
        tot++;
      end
      send($urandom, 3'($urandom_range(0, 7)), 1'b1, $urandom_range(0, 3) == 0);
      tot++;
    end
    valid <= 1'b0;
    send_done = 1;
  end

  // receiver: random stall before each word, plus one long hold-off
  initial begin
    int w;
    bit held;
    held = 0;
    forever begin
      if (hold_rx && !held) begin
        held = 1;
        w = 600;
      end else begin
        w = $urandom_range(0, 15);
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    digest_t e;
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest word %h", digest_word);
      end else begin
        e = digest_q.pop_front();
        if (e.word !== digest_word || e.idx !== word_index || e.lst !== last_of_digest) begin
          errors++;
          if (errors <= 10)
            $display("digest mismatch exp %h/%0d/%b got %h/%0d/%b", e.word, e.idx, e.lst,
                     digest_word, word_index, last_of_digest);
        end
      end
    end
  end

  initial begin
    wait (send_done);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && digest_q.size() == 0) $display("tb_sha256_message_digest_top OK");
    else $display("tb_sha256_message_digest_top NOT OK");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_sha256_message_digest_top NOT OK");
    $finish;
  end
endmodule

[files.f]
sv/sha_pkg.sv
sv/sha_round.sv
sv/sha256_message_digest_top.sv
tb/tb_sha256_message_digest_top.sv
